// ----- src/throttle_ramp_brake_command_top_macros.svh -----
// assertion macros used by the throttle ramp and brake command controller
`ifndef THROTTLE_RAMP_BRAKE_COMMAND_TOP_MACROS_SVH
`define THROTTLE_RAMP_BRAKE_COMMAND_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define TRBC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TRBC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/trbc_pkg.sv -----
// shared types, constants and lookup functions of the throttle ramp and brake command block
`default_nettype none

package trbc_pkg;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int DIV_DW      = 32;
  localparam int DIV_VW      = 10;

  localparam logic [9:0]         DEAD_BAND     = 10'd70;
  localparam logic signed [23:0] REGEN_MIN     = 24'sd100;
  localparam logic signed [33:0] DECEL_STEP    = 34'sd1600;
  localparam logic [26:0]        K_Q16         = 27'd68440803;
  localparam logic [7:0]         WHEEL_MIN     = 8'd10;
  localparam logic [7:0]         WHEEL_DEFAULT = 8'd90;
  localparam logic [7:0]         POLE_RESET    = 8'd30;
  localparam logic [7:0]         WHEEL_RESET   = 8'd100;

  localparam logic [7:0] CFG_POLE_COUNT = 8'd0;
  localparam logic [7:0] CFG_WHEEL      = 8'd1;

  localparam logic KIND_SPEED   = 1'b0;
  localparam logic KIND_CURRENT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_MUL_THR,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_RAMP,
    ST_SEND
  } trbc_state_t;

  typedef struct packed {
    logic in_ready;
    logic capture;
    logic mul_kp;
    logic mul_k;
    logic div_start;
    logic div_sel;
    logic load_limit;
    logic mul_thr;
    logic load_target;
    logic ramp;
    logic send;
  } trbc_cmd_t;

  typedef struct packed {
    logic skip;
    logic brake;
    logic div_busy;
    logic div_done;
    logic out_free;
  } trbc_status_t;

  // L1 -> 0, L2 -> 1, everything else -> L3
  function automatic logic [1:0] level_index(input logic [1:0] lvl);
    logic [1:0] li;
    case (lvl)
      2'd1:    li = 2'd0;
      2'd2:    li = 2'd1;
      default: li = 2'd2;
    endcase
    return li;
  endfunction

  function automatic logic [5:0] kmh_of(input logic open, input logic [1:0] li);
    logic [5:0] k;
    case (li)
      2'd0:    k = open ? 6'd7  : 6'd20;
      2'd1:    k = open ? 6'd15 : 6'd30;
      default: k = open ? 6'd25 : 6'd45;
    endcase
    return k;
  endfunction

  function automatic logic [9:0] full_of(input logic [1:0] li);
    logic [9:0] f;
    case (li)
      2'd0:    f = 10'd360;
      2'd1:    f = 10'd680;
      default: f = 10'd1000;
    endcase
    return f;
  endfunction

  function automatic logic [13:0] accel_step_of(input logic [2:0] acc);
    logic [13:0] s;
    case (acc)
      3'd0, 3'd1: s = 14'd200;
      3'd2:       s = 14'd400;
      3'd3:       s = 14'd800;
      3'd4:       s = 14'd1600;
      default:    s = 14'd10000;
    endcase
    return s;
  endfunction

  function automatic logic signed [7:0] brake_of(input logic [2:0] rec);
    logic signed [7:0] a;
    case (rec)
      3'd0:    a = 8'sd0;
      3'd1:    a = -8'sd10;
      3'd2:    a = -8'sd25;
      3'd3:    a = -8'sd50;
      3'd4:    a = -8'sd75;
      default: a = -8'sd100;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- src/trbc_div.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none

module trbc_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [trbc_pkg::DIV_DW-1:0]   dividend,
  input  wire logic [trbc_pkg::DIV_VW-1:0]   divisor,
  output logic                               busy,
  output logic                               done,
  output logic [trbc_pkg::DIV_DW-1:0]        quotient
);

  localparam int DW = trbc_pkg::DIV_DW;
  localparam int VW = trbc_pkg::DIV_VW;
  localparam int CW = $clog2(DW);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r, dvs_r;
  logic [DW-1:0] quo_r;

  logic [VW:0]   trial;
  logic          fits;
  logic [VW-1:0] rem_nxt;

  assign trial   = {rem_r, quo_r[DW-1]};
  assign fits    = trial >= {1'b0, dvs_r};
  assign rem_nxt = fits ? VW'(trial - {1'b0, dvs_r}) : trial[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- src/trbc_dp.sv -----
// datapath: item capture, speed limit and target arithmetic, ramp, held command and result register
`default_nettype none

module trbc_dp (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire trbc_pkg::trbc_cmd_t               cmd,
  output trbc_pkg::trbc_status_t                 status,
  input  wire logic [trbc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [7:0]                        pole_count,
  input  wire logic [7:0]                        wheel_tenth_inches,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [trbc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tuser
);

  // captured item
  logic [9:0]         thr_r;
  logic               brake_r;
  logic [1:0]         lvl_r;
  logic               open_r;
  logic [2:0]         acc_r;
  logic [2:0]         rec_r;
  logic               link_r;
  logic signed [23:0] meas_r;

  // arithmetic chain
  logic [13:0] mkp_r;
  logic [40:0] mk_r;
  logic [20:0] limit_r;
  logic [30:0] mthr_r;
  logic [30:0] target_r;
  logic signed [31:0] ramp_r;
  logic signed [31:0] held_r;

  // result register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [23:0] out_erpm_r;
  logic [7:0]  out_amps_r;

  logic [1:0]  li;
  logic [7:0]  wheel_eff;
  logic [9:0]  thr_in;
  logic [9:0]  thr_nxt;

  logic [trbc_pkg::DIV_DW-1:0] div_dividend;
  logic [trbc_pkg::DIV_VW-1:0] div_divisor;
  logic [trbc_pkg::DIV_DW-1:0] div_quotient;
  logic                        div_busy, div_done;

  logic signed [33:0] tgt_s, held_s, up_s, dn_s, ramp_nxt;
  logic signed [7:0]  amps_nxt;

  assign li        = trbc_pkg::level_index(lvl_r);
  assign wheel_eff = (wheel_tenth_inches < trbc_pkg::WHEEL_MIN) ?
                     trbc_pkg::WHEEL_DEFAULT : wheel_tenth_inches;
  assign thr_in    = in_tdata[9:0];
  assign thr_nxt   = (thr_in < trbc_pkg::DEAD_BAND) ? 10'd0 : thr_in;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      thr_r   <= thr_nxt;
      brake_r <= in_tdata[10];
      lvl_r   <= in_tdata[12:11];
      open_r  <= in_tdata[13];
      acc_r   <= in_tdata[16:14];
      rec_r   <= in_tdata[19:17];
      link_r  <= in_tdata[20];
      meas_r  <= signed'(in_tdata[44:21]);
    end
  end

  // two divisions share one unit: eRPM scale by wheel, then throttle scale by full travel
  assign div_dividend = cmd.div_sel ? {1'b0, mthr_r} : {7'b0, mk_r[40:16]};
  assign div_divisor  = cmd.div_sel ? trbc_pkg::full_of(li) : {2'b0, wheel_eff};

  trbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_kp) begin
      mkp_r <= {8'b0, trbc_pkg::kmh_of(open_r, li)} * {6'b0, pole_count};
    end
    if (cmd.mul_k) begin
      mk_r <= {27'b0, mkp_r} * {14'b0, trbc_pkg::K_Q16};
    end
    if (cmd.load_limit) begin
      limit_r <= div_quotient[20:0];
    end
    if (cmd.mul_thr) begin
      mthr_r <= {21'b0, thr_r} * {10'b0, limit_r};
    end
    if (cmd.load_target) begin
      target_r <= div_quotient[30:0];
    end
    if (cmd.ramp) begin
      ramp_r <= ramp_nxt[31:0];
    end
  end

  // ramp toward target, zero throttle drops a positive command at once
  always_comb begin
    tgt_s  = signed'({3'b000, target_r});
    held_s = signed'({{2{held_r[31]}}, held_r});
    up_s   = held_s + signed'({20'b0, trbc_pkg::accel_step_of(acc_r)});
    dn_s   = held_s - trbc_pkg::DECEL_STEP;
    if (tgt_s > held_s) begin
      ramp_nxt = (up_s > tgt_s) ? tgt_s : up_s;
    end else if (tgt_s < held_s) begin
      ramp_nxt = (dn_s < tgt_s) ? tgt_s : dn_s;
    end else begin
      ramp_nxt = held_s;
    end
    if ((thr_r == 10'd0) && (ramp_nxt > 34'sd0)) begin
      ramp_nxt = '0;
    end
  end

  // regen held at zero while slow
  assign amps_nxt = (meas_r > trbc_pkg::REGEN_MIN) ? trbc_pkg::brake_of(rec_r) : 8'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.send) begin
      held_r      <= brake_r ? signed'({{8{meas_r[23]}}, meas_r}) : ramp_r;
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      out_kind_r <= brake_r ? trbc_pkg::KIND_CURRENT : trbc_pkg::KIND_SPEED;
      out_erpm_r <= brake_r ? 24'd0 : ramp_r[23:0];
      out_amps_r <= brake_r ? amps_nxt : 8'd0;
    end
  end

  assign status.skip     = !link_r || (pole_count == 8'd0);
  assign status.brake    = brake_r;
  assign status.div_busy = div_busy;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_amps_r, out_erpm_r};
  assign out_tuser  = out_kind_r;

endmodule

`default_nettype wire

// ----- src/trbc_ctrl.sv -----
// controller state machine sequencing one command tick through the datapath
`default_nettype none

`include "throttle_ramp_brake_command_top_macros.svh"

module trbc_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire trbc_pkg::trbc_status_t  status,
  output trbc_pkg::trbc_cmd_t          cmd
);

  trbc_pkg::trbc_state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= trbc_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      trbc_pkg::ST_IDLE: begin
        if (in_valid) st_nxt = trbc_pkg::ST_CHECK;
      end
      trbc_pkg::ST_CHECK: begin
        if (status.skip)       st_nxt = trbc_pkg::ST_IDLE;
        else if (status.brake) st_nxt = trbc_pkg::ST_SEND;
        else                   st_nxt = trbc_pkg::ST_MUL;
      end
      trbc_pkg::ST_MUL:       st_nxt = trbc_pkg::ST_DIV1_GO;
      trbc_pkg::ST_DIV1_GO:   st_nxt = trbc_pkg::ST_DIV1_WAIT;
      trbc_pkg::ST_DIV1_WAIT: begin
        if (status.div_done) st_nxt = trbc_pkg::ST_MUL_THR;
      end
      trbc_pkg::ST_MUL_THR:   st_nxt = trbc_pkg::ST_DIV2_GO;
      trbc_pkg::ST_DIV2_GO:   st_nxt = trbc_pkg::ST_DIV2_WAIT;
      trbc_pkg::ST_DIV2_WAIT: begin
        if (status.div_done) st_nxt = trbc_pkg::ST_RAMP;
      end
      trbc_pkg::ST_RAMP:      st_nxt = trbc_pkg::ST_SEND;
      trbc_pkg::ST_SEND: begin
        if (status.out_free) st_nxt = trbc_pkg::ST_IDLE;
      end
      default:                st_nxt = trbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (st_r)
      trbc_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = in_valid;
      end
      trbc_pkg::ST_CHECK:     cmd.mul_kp = 1'b1;
      trbc_pkg::ST_MUL:       cmd.mul_k = 1'b1;
      trbc_pkg::ST_DIV1_GO:   cmd.div_start = 1'b1;
      trbc_pkg::ST_DIV1_WAIT: cmd.load_limit = status.div_done;
      trbc_pkg::ST_MUL_THR:   cmd.mul_thr = 1'b1;
      trbc_pkg::ST_DIV2_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      trbc_pkg::ST_DIV2_WAIT: begin
        cmd.div_sel     = 1'b1;
        cmd.load_target = status.div_done;
      end
      trbc_pkg::ST_RAMP:      cmd.ramp = 1'b1;
      trbc_pkg::ST_SEND:      cmd.send = status.out_free;
      default:                cmd = '0;
    endcase
  end

  `TRBC_ASSERT_IMPL(a_div_start_idle, cmd.div_start, !status.div_busy, "divider restarted while busy")
  `TRBC_ASSERT_IMPL(a_send_free, cmd.send, status.out_free, "result loaded over an untaken result")
  `TRBC_ASSERT_NEXT(a_accept_check, cmd.capture, st_r == trbc_pkg::ST_CHECK, "accepted item not checked")
  `TRBC_ASSERT_IMPL(a_done_waiting, status.div_done, st_r == trbc_pkg::ST_DIV1_WAIT || st_r == trbc_pkg::ST_DIV2_WAIT, "quotient ready outside a wait state")

endmodule

`default_nettype wire

// ----- src/throttle_ramp_brake_command_top.sv -----
// top level of the throttle ramp and brake command block
`default_nettype none

// One input transfer is one motor-command tick. When the link is down or the
// pole count is zero, the tick produces no result and the held command stays.
// With the brake pulled the block sends a current command (tuser = 1) with the
// regen current in 0.1 A units, zero while measured eRPM is at or below 100,
// and the held command takes the measured eRPM. Otherwise the throttle (below
// 70 counts as zero) is scaled onto the level's speed limit in eRPM, the held
// command ramps toward that target, and the low 24 bits go out as a speed
// command (tuser = 0). A speed tick runs two 32-step divisions in the one
// shared restoring divider. A brake tick goes from the check step straight
// to the send step, and a dropped tick from the check step back to idle. The
// block takes a new tick while the last result still waits on out_tready;
// that tick then stalls only at its own send step.
// Neither channel is ready while reset is held. Configuration writes are
// otherwise always ready and belong between ticks.

module throttle_ramp_brake_command_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [9:0] throttle, [10] brake_on, [12:11] speed_level, [13] profile_open,
  // [16:14] accel_level, [19:17] recup_level, [20] link_up,
  // [44:21] measured_erpm, [47:45] zero
  input  wire logic [trbc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [23:0] erpm_command, [31:24] brake_deciamps
  output logic [trbc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // [0] command_kind
  output logic                                   out_tuser,
  // configuration write channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [7:0]                        cfg_index,
  input  wire logic [7:0]                        cfg_data
);

  trbc_pkg::trbc_cmd_t    cmd;
  trbc_pkg::trbc_status_t status;

  // configuration registers
  logic [7:0] pole_r;
  logic [7:0] wheel_r;

  assign cfg_ready = rst_n;

  // writes to indexes outside the register list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r  <= trbc_pkg::POLE_RESET;
      wheel_r <= trbc_pkg::WHEEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        trbc_pkg::CFG_POLE_COUNT: pole_r  <= cfg_data;
        trbc_pkg::CFG_WHEEL:      wheel_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencing
  trbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, held command and result register
  trbc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_tdata           (in_tdata),
    .pole_count         (pole_r),
    .wheel_tenth_inches (wheel_r),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .out_tuser          (out_tuser)
  );

  // no transfer is taken while reset is held
  assign in_tready = cmd.in_ready && rst_n;

endmodule

`default_nettype wire

// ----- sim/tb_throttle_ramp_brake_command_top.sv -----
// testbench for the throttle ramp and brake command block: directed table, then random ticks
module tb_throttle_ramp_brake_command_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trbc_pkg::*;

  // timing of the run
  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 100;     // covers a whole speed tick
  localparam int DRAIN_LIMIT   = 20000;   // cycles to wait for outstanding commands

  // behavior constants of the command path
  localparam int              DEADBAND_CNT     = 70;
  localparam int              REGEN_FLOOR_ERPM = 100;
  localparam longint          RAMP_DOWN_STEP   = 1600;
  localparam longint unsigned WHEEL_K          = 64'd68440803;  // 65536 * 10000 / (3.048 * pi)

  // one motor-command tick as the sender sees it
  typedef struct packed {
    logic [9:0]         throttle;
    logic               brake_on;
    logic [1:0]         speed_level;
    logic               profile_open;
    logic [2:0]         accel_level;
    logic [2:0]         recup_level;
    logic               link_up;
    logic signed [23:0] measured_erpm;
  } tick_t;

  // one motor command as it leaves the block
  typedef struct packed {
    logic               kind;
    logic signed [23:0] erpm;
    logic signed [7:0]  amps;
  } cmd_t;

  // how a directed row gets its expected command
  typedef enum logic [1:0] {
    ROW_PREDICT,   // worked out by the predictor
    ROW_TYPED,     // written in the row
    ROW_QUIET      // no command at all
  } row_check_t;

  typedef struct packed {
    tick_t      t;
    row_check_t chk;
    cmd_t       res;
  } dir_row_t;

  typedef struct packed {
    logic [7:0]  pole;
    logic [7:0]  wheel;
    int unsigned ticks;
    int unsigned send_pct;
    int unsigned recv_pct;
  } phase_t;

  localparam cmd_t NO_CMD = '0;

  // per-level tables of the drive profile
  int unsigned kmh_open_tbl   [3] = '{7, 15, 25};
  int unsigned kmh_closed_tbl [3] = '{20, 30, 45};
  int unsigned full_tbl       [3] = '{360, 680, 1000};
  int          accel_tbl      [5] = '{200, 400, 800, 1600, 10000};
  int          regen_tbl      [6] = '{0, -10, -25, -50, -75, -100};

  // directed ticks, run with the register values left by reset
  // fields: throttle, brake, level, open, accel, recup, link, measured erpm
  dir_row_t dir_tbl [24] = '{
    // link down: nothing goes out
    '{'{1023, 0, 3, 0, 1, 0, 0, 0},        ROW_QUIET,   NO_CMD},
    // full regen at top speed
    '{'{0, 1, 1, 0, 1, 5, 1, 8388607},     ROW_TYPED,   '{KIND_CURRENT, 0, -100}},
    // brake with link down is dropped too
    '{'{512, 1, 2, 1, 2, 5, 0, 4000},      ROW_QUIET,   NO_CMD},
    // regen level zero
    '{'{0, 1, 1, 0, 1, 0, 1, 101},         ROW_TYPED,   '{KIND_CURRENT, 0, 0}},
    // brake right at the slow threshold holds zero current
    '{'{0, 1, 1, 0, 1, 3, 1, 100},         ROW_TYPED,   '{KIND_CURRENT, 0, 0}},
    // most negative speed, recup level above range
    '{'{1023, 1, 3, 1, 5, 7, 1, -8388608}, ROW_TYPED,   '{KIND_CURRENT, 0, 0}},
    // climb back from the most negative held command
    '{'{0, 0, 1, 0, 5, 0, 1, 0},           ROW_PREDICT, NO_CMD},
    '{'{0, 1, 2, 0, 1, 6, 1, 5000},        ROW_TYPED,   '{KIND_CURRENT, 0, -100}},
    '{'{0, 1, 2, 0, 1, 1, 1, 102},         ROW_TYPED,   '{KIND_CURRENT, 0, -10}},
    '{'{0, 1, 3, 0, 1, 2, 1, 2000},        ROW_TYPED,   '{KIND_CURRENT, 0, -25}},
    '{'{0, 1, 3, 0, 1, 4, 1, 8388607},     ROW_TYPED,   '{KIND_CURRENT, 0, -75}},
    // throttle just inside the dead band zeroes a positive command
    '{'{69, 0, 3, 1, 5, 0, 1, 0},          ROW_TYPED,   '{KIND_SPEED, 0, 0}},
    // throttle at the dead band edge, then every accel step
    '{'{70, 0, 1, 0, 1, 0, 1, 0},          ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 1, 0, 0, 0, 1, 0},        ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 0, 1, 7, 0, 1, 0},        ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 2, 1, 6, 0, 1, 0},        ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 2, 0, 2, 0, 1, 0},        ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 3, 0, 3, 0, 1, 0},        ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 3, 0, 4, 0, 1, 0},        ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 3, 0, 5, 0, 1, 8388607},  ROW_PREDICT, NO_CMD},
    '{'{1023, 0, 3, 0, 5, 0, 1, -1},       ROW_PREDICT, NO_CMD},
    // lower target: ramp down
    '{'{500, 0, 3, 0, 5, 0, 1, 0},         ROW_PREDICT, NO_CMD},
    // release throttle with a positive command
    '{'{0, 0, 3, 0, 5, 0, 1, 0},           ROW_TYPED,   '{KIND_SPEED, 0, 0}},
    '{'{512, 0, 2, 0, 3, 0, 0, 1234},      ROW_QUIET,   NO_CMD}
  };

  // dut signals, the ones driven here known from time zero
  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_index  = '0;
  logic [7:0]             cfg_data   = '0;

  // predictor copy of the registers and the held command
  logic [7:0] pole_cfg  = POLE_RESET;
  logic [7:0] wheel_cfg = WHEEL_RESET;
  longint     held_cmd  = 0;

  // commands still owed by the block, oldest first
  cmd_t        cmd_q [$];
  int unsigned err_count     = 0;
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 77;

  throttle_ramp_brake_command_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // receiver stalls at random at the current rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    err_count++;
  endtask

  // what one tick commands; updates the held command like the block does
  function automatic bit predict_command(input tick_t t, output cmd_t c);
    longint unsigned kmh;
    longint unsigned wheel;
    longint unsigned limit;
    longint          target;
    longint          next_held;
    int unsigned     li;
    int unsigned     acc;
    int unsigned     rec;
    int unsigned     thr;
    c = '0;
    // dropped tick: state untouched
    if (!t.link_up || pole_cfg == 8'd0) return 1'b0;
    if (t.brake_on) begin
      rec = (t.recup_level > 3'd5) ? 5 : t.recup_level;
      c.kind = KIND_CURRENT;
      // no regen while slow or reversing
      if (t.measured_erpm > REGEN_FLOOR_ERPM) c.amps = 8'(regen_tbl[rec]);
      held_cmd = t.measured_erpm;
      return 1'b1;
    end
    thr   = (t.throttle < DEADBAND_CNT) ? 0 : t.throttle;
    // level zero runs as the third level
    li    = (t.speed_level == 2'd1) ? 0 : (t.speed_level == 2'd2) ? 1 : 2;
    kmh   = t.profile_open ? kmh_open_tbl[li] : kmh_closed_tbl[li];
    wheel = (wheel_cfg < 8'd10) ? 90 : wheel_cfg;
    // speed limit in erpm, truncated
    limit  = (kmh * pole_cfg * WHEEL_K) / (wheel * 65536);
    // throttle above full scale is not clamped
    target = longint'((thr * limit) / full_tbl[li]);
    acc    = (t.accel_level == 3'd0) ? 1 : (t.accel_level > 3'd5) ? 5 : t.accel_level;
    if (target > held_cmd) begin
      next_held = held_cmd + accel_tbl[acc - 1];
      held_cmd  = (next_held > target) ? target : next_held;
    end else if (target < held_cmd) begin
      next_held = held_cmd - RAMP_DOWN_STEP;
      held_cmd  = (next_held < target) ? target : next_held;
    end
    // released throttle drops a forward command at once
    if (thr == 0 && held_cmd > 0) held_cmd = 0;
    c.kind = KIND_SPEED;
    c.erpm = held_cmd[23:0];
    return 1'b1;
  endfunction

  // mostly steady riding with occasional changes, so ramps can reach their targets
  function automatic tick_t next_random_tick(input tick_t prev);
    tick_t       t;
    int unsigned roll;
    t    = prev;
    roll = $urandom_range(99);
    if (roll < 12) t.throttle = 10'($urandom_range(DEADBAND_CNT - 1));
    else if (roll < 20) t.throttle = 10'd1023;
    else if (roll < 45) t.throttle = 10'($urandom_range(1023));
    if ($urandom_range(99) < 15) t.speed_level = 2'($urandom_range(3));
    if ($urandom_range(99) < 10) t.profile_open = 1'($urandom_range(1));
    if ($urandom_range(99) < 20) t.accel_level = 3'($urandom_range(7));
    t.recup_level = 3'($urandom_range(7));
    t.brake_on    = ($urandom_range(99) < 18);
    t.link_up     = ($urandom_range(99) < 94);
    // low speeds around the regen threshold, or anything
    if ($urandom_range(99) < 45) t.measured_erpm = 24'($urandom_range(400)) - 24'sd150;
    else t.measured_erpm = 24'($urandom());
    return t;
  endfunction

  // one input transfer, with random gaps ahead of it
  task automatic send_tick(input tick_t t, input row_check_t chk, input cmd_t given);
    cmd_t want;
    bit   fires;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, t.measured_erpm, t.link_up, t.recup_level, t.accel_level,
                  t.profile_open, t.speed_level, t.brake_on, t.throttle};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transfer taken at this edge
    fires = predict_command(t, want);
    if (chk == ROW_TYPED) cmd_q.push_back(given);
    else if (chk == ROW_PREDICT && fires) cmd_q.push_back(want);
  endtask

  // stop sending and let every owed command come out, then let the block settle
  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (cmd_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_POLE_COUNT) pole_cfg = val;
    else if (idx == CFG_WHEEL) wheel_cfg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // every result transfer against the oldest owed command
  always @(posedge clk) begin : result_check
    cmd_t got;
    cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.erpm = out_tdata[23:0];
      got.amps = out_tdata[31:24];
      if (cmd_q.size() == 0) begin
        report_mismatch("command came out with none owed");
      end else begin
        want = cmd_q.pop_front();
        if (got.kind !== want.kind)
          report_mismatch($sformatf("command kind %0d, wanted %0d", got.kind, want.kind));
        if (got.erpm !== want.erpm)
          report_mismatch($sformatf("erpm command %0d, wanted %0d", got.erpm, want.erpm));
        if (got.amps !== want.amps)
          report_mismatch($sformatf("brake current %0d, wanted %0d", got.amps, want.amps));
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    tick_t  t;
    phase_t plan [6];
    // register settings with their idle pattern: sender-light first, then
    // receiver-light, then both at full rate
    plan[0] = '{POLE_RESET, WHEEL_RESET, 250, 33, 77};
    plan[1] = '{8'd255, 8'd0, 250, 33, 77};               // wheel below minimum, largest pole count
    plan[2] = '{8'd1, 8'd255, 250, 77, 33};               // smallest limit
    plan[3] = '{8'd0, 8'($urandom_range(255)), 40, 77, 33}; // pole count zero drops all
    plan[4] = '{8'($urandom_range(1, 255)), 8'd9, 250, 0, 0};
    plan[5] = '{8'($urandom_range(1, 255)), 8'($urandom_range(10, 255)), 250, 0, 0};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table on reset register values
    foreach (dir_tbl[i]) begin
      t = dir_tbl[i].t;
      send_tick(t, dir_tbl[i].chk, dir_tbl[i].res);
    end

    for (int p = 0; p < 6; p++) begin
      // registers only change with the block idle
      drain_results();
      write_reg(CFG_POLE_COUNT, plan[p].pole);
      write_reg(CFG_WHEEL, plan[p].wheel);
      send_idle_pct = plan[p].send_pct;
      recv_idle_pct = plan[p].recv_pct;
      for (int i = 0; i < plan[p].ticks; i++) begin
        t = next_random_tick(t);
        send_tick(t, ROW_PREDICT, NO_CMD);
        // sender holds off until the block has caught up
        if (i == plan[p].ticks / 2 || $urandom_range(79) == 0) drain_results();
      end
    end

    drain_results();
    if (cmd_q.size() != 0)
      report_mismatch($sformatf("%0d commands never came out", cmd_q.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
